/* src/sbr_pkg.sv */
// Shared types and codes for the switch branch resolver.
`default_nettype none

package sbr_pkg;

    // action codes of an input word
    localparam logic [1:0] ACT_HEADER  = 2'd0;
    localparam logic [1:0] ACT_ENTRY   = 2'd1;
    localparam logic [1:0] ACT_RESOLVE = 2'd2;

    // table kinds
    localparam logic KIND_RANGE = 1'b0;
    localparam logic KIND_KEY   = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_HDR  = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HDR,
        ST_RLO,
        ST_RHI,
        ST_RDATA,
        ST_KPROBE,
        ST_KCMP,
        ST_DONE
    } t_state;

    // compare flags of the shared subtractor
    typedef struct packed {
        logic lt;
        logic eq;
    } t_alu_flags;

endpackage

`default_nettype wire

/* src/sbr_in_if.sv */
// Input channel of the switch branch resolver: valid/ready plus item fields.
`default_nettype none

interface sbr_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic               switch_kind;
    logic signed [31:0] default_offset;
    logic signed [31:0] low_bound;
    logic signed [31:0] high_bound;
    logic [8:0]         pair_count;
    logic signed [31:0] entry_key;
    logic signed [31:0] entry_offset;
    logic signed [31:0] switch_value;

    modport source (
        output valid, action, switch_kind, default_offset, low_bound, high_bound,
               pair_count, entry_key, entry_offset, switch_value,
        input  ready
    );

    modport sink (
        input  valid, action, switch_kind, default_offset, low_bound, high_bound,
               pair_count, entry_key, entry_offset, switch_value,
        output ready
    );
endinterface

`default_nettype wire

/* src/sbr_out_if.sv */
// Result channel of the switch branch resolver: valid/ready plus result fields.
`default_nettype none

interface sbr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] branch_offset;
    logic               matched;
    logic [1:0]         status;

    modport source (
        output valid, branch_offset, matched, status,
        input  ready
    );

    modport sink (
        input  valid, branch_offset, matched, status,
        output ready
    );
endinterface

`default_nettype wire

/* src/switch_branch_resolver_core.sv */
// Top level of the switch branch resolver: sequencer, table state, result register.
//
// Usage: words arrive on i_in (valid/ready). A header word sets the table kind,
// default offset and bounds or pair count; entry words then fill the table slot
// by slot; a resolve word looks up a switch value and yields one result word on
// o_out. Headers and entries give no result.
// Steps: an entry below capacity is written as it is accepted; a header adds a
// size-check step. A range-table resolve makes two subtractor passes and one
// memory read, and on a miss ends without using the read. A key-table resolve
// makes P binary-search probes (at most ceil(log2(count+1))); each probe is one
// registered memory read followed by one compare on the shared subtractor.
// A resolve after an invalid header goes straight to the final step.
// The input takes the next word in the cycle after the result loads.
// i_in.ready is high only while the sequencer is idle, one word at a time.
// Reset clears the table header state except the pair count (range table
// covering value 0) but not the memories. A stalled receiver holds the result
// in the output register; headers and entries are still taken meanwhile, and
// the next resolve waits in its final step until the output register is free.
`default_nettype none

module switch_branch_resolver_core #(
    parameter int MAX_ENTRIES = 256
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sbr_in_if.sink      i_in,
    sbr_out_if.source   o_out
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [32:0] MAX_M1 = 33'(MAX_ENTRIES - 1);
    localparam logic [31:0] MAX_W  = 32'(MAX_ENTRIES);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);

    sbr_pkg::t_state r_state, n_state;

    // table header state
    logic               r_kind;
    logic signed [31:0] r_default;
    logic signed [31:0] r_lo;
    logic signed [31:0] r_hi;
    logic [8:0]         r_pairs;
    logic [CW-1:0]      r_total;
    logic [CW-1:0]      r_fill;
    logic               r_bad;
    logic               r_ovf;

    // resolve working registers
    logic signed [31:0] r_val;
    logic [32:0]        r_diff;
    logic signed [CW:0] r_klo;
    logic signed [CW:0] r_khi;
    logic [CW-1:0]      r_mid;
    logic [31:0]        r_res_off;
    logic               r_res_hit;
    logic [1:0]         r_res_status;

    // output register
    logic               r_out_valid;
    logic [31:0]        r_out_off;
    logic               r_out_hit;
    logic [1:0]         r_out_status;

    // shared unit and memory hookup
    logic signed [31:0]  alu_a, alu_b;
    logic [32:0]         alu_diff;
    sbr_pkg::t_alu_flags alu_flags;
    logic                mem_we;
    logic [AW-1:0]       mem_raddr;
    logic [31:0]         mem_rkey, mem_roff;

    logic          in_ready;
    logic          in_accept;
    logic          out_free;
    logic          val_above;
    logic          search_empty;
    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid;

    assign in_accept    = i_in.valid && in_ready;
    assign out_free     = !r_out_valid || o_out.ready;
    assign val_above    = !alu_flags.lt && !alu_flags.eq;
    assign search_empty = (r_klo > r_khi);
    assign mid_sum      = {1'b0, r_klo[CW-1:0]} + {1'b0, r_khi[CW-1:0]};
    assign mid          = mid_sum[CW:1];

    sbr_alu u_alu (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_diff  (alu_diff),
        .o_flags (alu_flags)
    );

    sbr_store #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_fill[AW-1:0]),
        .i_wkey  (i_in.entry_key),
        .i_woff  (i_in.entry_offset),
        .i_raddr (mem_raddr),
        .o_rkey  (mem_rkey),
        .o_roff  (mem_roff)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sbr_pkg::ST_IDLE: begin
                if (in_accept) begin
                    case (i_in.action)
                        sbr_pkg::ACT_HEADER: n_state = sbr_pkg::ST_HDR;
                        sbr_pkg::ACT_RESOLVE: begin
                            if (r_bad) begin
                                n_state = sbr_pkg::ST_DONE;
                            end else if (r_kind == sbr_pkg::KIND_RANGE) begin
                                n_state = sbr_pkg::ST_RLO;
                            end else begin
                                n_state = sbr_pkg::ST_KPROBE;
                            end
                        end
                        default: n_state = sbr_pkg::ST_IDLE;
                    endcase
                end
            end
            sbr_pkg::ST_HDR:   n_state = sbr_pkg::ST_IDLE;
            sbr_pkg::ST_RLO:   n_state = sbr_pkg::ST_RHI;
            sbr_pkg::ST_RHI: begin
                if (r_diff[32] || val_above) begin
                    n_state = sbr_pkg::ST_DONE;
                end else begin
                    n_state = sbr_pkg::ST_RDATA;
                end
            end
            sbr_pkg::ST_RDATA: n_state = sbr_pkg::ST_DONE;
            sbr_pkg::ST_KPROBE: begin
                if (search_empty) begin
                    n_state = sbr_pkg::ST_DONE;
                end else begin
                    n_state = sbr_pkg::ST_KCMP;
                end
            end
            sbr_pkg::ST_KCMP: begin
                if (alu_flags.eq) begin
                    n_state = sbr_pkg::ST_DONE;
                end else begin
                    n_state = sbr_pkg::ST_KPROBE;
                end
            end
            sbr_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = sbr_pkg::ST_IDLE;
                end
            end
            default: n_state = sbr_pkg::ST_IDLE;
        endcase
    end

    // control outputs: handshake, shared unit operands, memory ports
    always_comb begin
        in_ready  = 1'b0;
        alu_a     = r_val;
        alu_b     = r_lo;
        mem_raddr = '0;
        case (r_state)
            sbr_pkg::ST_IDLE: in_ready = 1'b1;
            sbr_pkg::ST_HDR: begin
                alu_a = r_hi;
                alu_b = r_lo;
            end
            sbr_pkg::ST_RLO: begin
                alu_a = r_val;
                alu_b = r_lo;
            end
            sbr_pkg::ST_RHI: begin
                alu_a     = r_val;
                alu_b     = r_hi;
                mem_raddr = r_diff[AW-1:0];
            end
            sbr_pkg::ST_KPROBE: mem_raddr = mid[AW-1:0];
            sbr_pkg::ST_KCMP: begin
                alu_a = r_val;
                alu_b = mem_rkey;
            end
            default: in_ready = 1'b0;
        endcase
    end

    assign mem_we     = in_accept && (i_in.action == sbr_pkg::ACT_ENTRY) && (r_fill < MAX_C);
    assign i_in.ready = in_ready;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // table state and resolve datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind      <= sbr_pkg::KIND_RANGE;
            r_default   <= '0;
            r_lo        <= '0;
            r_hi        <= '0;
            r_total     <= '0;
            r_fill      <= '0;
            r_bad       <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the taken word unless a new one loads in this cycle
            if (o_out.ready && !((r_state == sbr_pkg::ST_DONE) && out_free)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                sbr_pkg::ST_IDLE: begin
                    if (in_accept) begin
                        case (i_in.action)
                            sbr_pkg::ACT_HEADER: begin
                                r_kind    <= i_in.switch_kind;
                                r_default <= i_in.default_offset;
                                r_lo      <= i_in.low_bound;
                                r_hi      <= i_in.high_bound;
                                r_pairs   <= i_in.pair_count;
                                r_fill    <= '0;
                                r_ovf     <= 1'b0;
                                r_bad     <= 1'b0;
                            end
                            sbr_pkg::ACT_ENTRY: begin
                                if (r_fill < MAX_C) begin
                                    r_fill <= r_fill + CW'(1);
                                end else begin
                                    r_ovf <= 1'b1;
                                end
                            end
                            sbr_pkg::ACT_RESOLVE: begin
                                r_val     <= i_in.switch_value;
                                r_klo     <= '0;
                                r_khi     <= {1'b0, r_total} - (CW+1)'(1);
                                r_res_off <= r_bad ? 32'd0 : r_default;
                                r_res_hit <= 1'b0;
                                if (r_bad) begin
                                    r_res_status <= sbr_pkg::STATUS_BAD_HDR;
                                end else if (r_ovf) begin
                                    r_res_status <= sbr_pkg::STATUS_OVERFLOW;
                                end else begin
                                    r_res_status <= sbr_pkg::STATUS_OK;
                                end
                            end
                            default: r_fill <= r_fill;
                        endcase
                    end
                end
                // size check: range uses hi - lo, key uses pair count
                sbr_pkg::ST_HDR: begin
                    if (r_kind == sbr_pkg::KIND_RANGE) begin
                        if (alu_flags.lt || (alu_diff > MAX_M1)) begin
                            r_bad   <= 1'b1;
                            r_total <= '0;
                        end else begin
                            r_total <= alu_diff[CW-1:0] + CW'(1);
                        end
                    end else begin
                        if ({23'd0, r_pairs} > MAX_W) begin
                            r_bad   <= 1'b1;
                            r_total <= '0;
                        end else begin
                            r_total <= CW'(r_pairs);
                        end
                    end
                end
                sbr_pkg::ST_RLO: r_diff <= alu_diff;
                sbr_pkg::ST_RDATA: begin
                    r_res_off <= mem_roff;
                    r_res_hit <= 1'b1;
                end
                sbr_pkg::ST_KPROBE: r_mid <= mid;
                sbr_pkg::ST_KCMP: begin
                    if (alu_flags.eq) begin
                        r_res_off <= mem_roff;
                        r_res_hit <= 1'b1;
                    end else if (alu_flags.lt) begin
                        r_khi <= {1'b0, r_mid} - (CW+1)'(1);
                    end else begin
                        r_klo <= {1'b0, r_mid} + (CW+1)'(1);
                    end
                end
                sbr_pkg::ST_DONE: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_off    <= r_res_off;
                        r_out_hit    <= r_res_hit;
                        r_out_status <= r_res_status;
                    end
                end
                default: r_diff <= r_diff;
            endcase
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.branch_offset = r_out_off;
    assign o_out.matched       = r_out_hit;
    assign o_out.status        = r_out_status;

    // a compare step always follows a probe that issued its read
    a_kcmp_after_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sbr_pkg::ST_KCMP) |-> ($past(r_state) == sbr_pkg::ST_KPROBE))
        else $error("key compare without a preceding probe");

    // an entry below capacity advances the fill index by one
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_in.action == sbr_pkg::ACT_ENTRY) && (r_fill < MAX_C))
        |=> (r_fill == $past(r_fill) + CW'(1)))
        else $error("fill index did not advance on entry");

    // a bad header never reports a hit
    a_bad_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == sbr_pkg::STATUS_BAD_HDR)) |-> !r_out_hit)
        else $error("hit reported with invalid header");

    // the result register is loaded only from the final step
    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == sbr_pkg::ST_DONE))
        else $error("result word appeared outside the final step");

endmodule

`default_nettype wire

/* src/sbr_alu.sv */
// Shared 33-bit signed subtractor with compare flags.
`default_nettype none

module sbr_alu (
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    output logic [32:0]             o_diff,
    output sbr_pkg::t_alu_flags     o_flags
);

    // sign-extend both operands so the difference never wraps
    assign o_diff        = {i_a[31], i_a} - {i_b[31], i_b};
    assign o_flags.lt    = o_diff[32];
    assign o_flags.eq    = (o_diff == 33'd0);

endmodule

`default_nettype wire

/* src/sbr_store.sv */
// Key and offset table memories: one write port, one registered read port.
`default_nettype none

module sbr_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [31:0]       i_wkey,
    input  wire logic [31:0]       i_woff,
    input  wire logic [AW-1:0]     i_raddr,
    output logic [31:0]            o_rkey,
    output logic [31:0]            o_roff
);

    logic [31:0] r_keys [DEPTH];
    logic [31:0] r_offs [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_keys[i_waddr] <= i_wkey;
            r_offs[i_waddr] <= i_woff;
        end
    end

    // registered read, both tables at the same slot
    always_ff @(posedge i_clk) begin
        o_rkey <= r_keys[i_raddr];
        o_roff <= r_offs[i_raddr];
    end

endmodule

`default_nettype wire
